FILE: hw/rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: shared widths, constants and types for the quaternion rotator
// Holds the fixed-point formats of the quaternion, the matrix entries, the
// product terms and the accumulators, plus the structs passed between stages.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int VECTOR_WIDTH   = 16;
    localparam int QUAT_WIDTH     = 16;

    // Matrix entries carry twice the quaternion fraction bits.
    localparam int FRAC_SHIFT = 2 * QUAT_FRAC_BITS;
    localparam int PROD_W     = 2 * QUAT_WIDTH;
    localparam int ENT_W      = (PROD_W + 2 > FRAC_SHIFT + 2) ? PROD_W + 2 : FRAC_SHIFT + 2;
    localparam int TERM_W     = ENT_W + VECTOR_WIDTH;
    localparam int ACC_W      = TERM_W + 2;

    localparam int IN_RAW_W   = 4 * QUAT_WIDTH + 3 * VECTOR_WIDTH;
    localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = 3 * VECTOR_WIDTH;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef logic signed [QUAT_WIDTH-1:0]   t_qcomp;
    typedef logic signed [VECTOR_WIDTH-1:0] t_vec;
    typedef logic signed [PROD_W-1:0]       t_qprod;
    typedef logic signed [ENT_W-1:0]        t_entry;
    typedef logic signed [TERM_W-1:0]       t_term;
    typedef logic signed [ACC_W-1:0]        t_acc;

    typedef t_vec [2:0] t_vec3;

    localparam t_entry ENT_ONE  = t_entry'(1) << FRAC_SHIFT;
    localparam t_acc   ACC_HALF = t_acc'(1) << (FRAC_SHIFT - 1);
    localparam t_acc   VEC_MAX  = (t_acc'(1) << (VECTOR_WIDTH - 1)) - t_acc'(1);
    localparam t_acc   VEC_MIN  = -(t_acc'(1) << (VECTOR_WIDTH - 1));

    // Direction codes carried in the input tuser bit.
    localparam logic DIR_BODY_TO_EARTH = 1'b0;
    localparam logic DIR_EARTH_TO_BODY = 1'b1;

    typedef struct packed {
        t_qcomp w;
        t_qcomp x;
        t_qcomp y;
        t_qcomp z;
    } t_quat;

    // Stage 1: the nine quaternion products.
    typedef struct packed {
        t_qprod xx;
        t_qprod yy;
        t_qprod zz;
        t_qprod xy;
        t_qprod xz;
        t_qprod yz;
        t_qprod wx;
        t_qprod wy;
        t_qprod wz;
        logic   dir;
        t_vec3  vec;
    } t_qprods;

    // Stage 2: matrix already oriented for the chosen direction, m[row][col].
    typedef struct packed {
        t_entry [2:0][2:0] m;
        t_vec3             vec;
    } t_mat;

    typedef t_acc [2:0] t_acc3;

    typedef struct packed {
        t_vec3 vec;
        logic  sat;
    } t_result;

endpackage

FILE: hw/rtl/quaternion_vector_rotation.sv
// Throughput: one transaction per cycle unless the output stalls.
// The pipeline is five register stages deep.
// The output stage is a register, so a new input is taken while a result waits.
// A stalled output fills the stages one by one; nothing is dropped or repeated.
// Reset (i_rst_n low at a clock edge) empties every stage; only the valid flags are reset.
// ----------------------------------------------------------------------------
// quaternion_vector_rotation: rotate a 3D vector by an attitude quaternion
// Builds the rotation matrix from a Q1.14 quaternion, multiplies it (or its
// transpose) with a signed vector, rounds to nearest and saturates.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0 up: q_w, q_x, q_y, q_z, vec_x, vec_y, vec_z.
    input  logic [qvr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: opcode (0 body to earth, 1 earth to body).
    input  logic [0:0]                      s_axis_tuser,
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0 up: out_x, out_y, out_z, then zero padding if any.
    output logic [qvr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: saturated.
    output logic [0:0]                      m_axis_tuser
);

    localparam int QW = qvr_pkg::QUAT_WIDTH;
    localparam int VW = qvr_pkg::VECTOR_WIDTH;

    qvr_pkg::t_quat    w_quat;
    qvr_pkg::t_vec3    w_vec;
    qvr_pkg::t_mat     w_mat;
    qvr_pkg::t_acc3    w_acc;
    qvr_pkg::t_result  w_result;
    logic              w_mat_valid;
    logic              w_mat_ready;
    logic              w_acc_valid;
    logic              w_acc_ready;

    // Unpack the input transaction. Field order follows the tdata comment above.
    assign w_quat.w = qvr_pkg::t_qcomp'(s_axis_tdata[0*QW +: QW]);
    assign w_quat.x = qvr_pkg::t_qcomp'(s_axis_tdata[1*QW +: QW]);
    assign w_quat.y = qvr_pkg::t_qcomp'(s_axis_tdata[2*QW +: QW]);
    assign w_quat.z = qvr_pkg::t_qcomp'(s_axis_tdata[3*QW +: QW]);
    assign w_vec[0] = qvr_pkg::t_vec'(s_axis_tdata[4*QW + 0*VW +: VW]);
    assign w_vec[1] = qvr_pkg::t_vec'(s_axis_tdata[4*QW + 1*VW +: VW]);
    assign w_vec[2] = qvr_pkg::t_vec'(s_axis_tdata[4*QW + 2*VW +: VW]);

    // Stages 1 and 2: quaternion products and the oriented rotation matrix.
    qvr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_dir   (s_axis_tuser[0]),
        .i_quat  (w_quat),
        .i_vec   (w_vec),
        .o_valid (w_mat_valid),
        .i_ready (w_mat_ready),
        .o_mat   (w_mat)
    );

    // Stages 3 and 4: entry-by-component products and the exact row sums.
    qvr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mat_valid),
        .o_ready (w_mat_ready),
        .i_mat   (w_mat),
        .o_valid (w_acc_valid),
        .i_ready (w_acc_ready),
        .o_acc   (w_acc)
    );

    // Stage 5: round, saturate and hold the result for the output stream.
    qvr_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_acc_valid),
        .o_ready  (w_acc_ready),
        .i_acc    (w_acc),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    // Pack the result; any bits above the three components are zero.
    assign m_axis_tdata    = qvr_pkg::OUT_DATA_W'({w_result.vec[2], w_result.vec[1],
                                                   w_result.vec[0]});
    assign m_axis_tuser[0] = w_result.sat;

    // The saturation flag may only be set when some component sits on a bound.
    a_sat_on_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_result.sat) |->
            (w_result.vec[0] == qvr_pkg::t_vec'(qvr_pkg::VEC_MAX)
          || w_result.vec[0] == qvr_pkg::t_vec'(qvr_pkg::VEC_MIN)
          || w_result.vec[1] == qvr_pkg::t_vec'(qvr_pkg::VEC_MAX)
          || w_result.vec[1] == qvr_pkg::t_vec'(qvr_pkg::VEC_MIN)
          || w_result.vec[2] == qvr_pkg::t_vec'(qvr_pkg::VEC_MAX)
          || w_result.vec[2] == qvr_pkg::t_vec'(qvr_pkg::VEC_MIN)))
        else $error("saturation flag set with no component on a bound");

    // With the output stage empty, the whole pipeline must be able to move.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output stage is empty");

    // With the accumulate and output stages empty, no result can appear at once.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_acc_valid && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared without passing the accumulate stage");

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

FILE: hw/rtl/qvr_matrix.sv
// ----------------------------------------------------------------------------
// qvr_matrix: rotation matrix builder
// Two pipeline stages: quaternion products, then matrix entries with the
// transpose applied for the earth-to-body direction.
// ----------------------------------------------------------------------------
module qvr_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_dir,
    input  qvr_pkg::t_quat i_quat,
    input  qvr_pkg::t_vec3 i_vec,
    output logic          o_valid,
    input  logic          i_ready,
    output qvr_pkg::t_mat o_mat
);

    logic             r_s1_valid;
    qvr_pkg::t_qprods r_s1;
    qvr_pkg::t_qprods n_s1;
    logic             r_s2_valid;
    qvr_pkg::t_mat    r_s2;
    qvr_pkg::t_mat    n_s2;
    qvr_pkg::t_entry [2:0][2:0] w_m;
    logic             w_s1_ready;
    logic             w_s2_ready;

    assign w_s2_ready = !r_s2_valid || i_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_ready    = w_s1_ready;
    assign o_valid    = r_s2_valid;
    assign o_mat      = r_s2;

    always_comb begin
        n_s1.xx  = qvr_pkg::t_qprod'(i_quat.x) * qvr_pkg::t_qprod'(i_quat.x);
        n_s1.yy  = qvr_pkg::t_qprod'(i_quat.y) * qvr_pkg::t_qprod'(i_quat.y);
        n_s1.zz  = qvr_pkg::t_qprod'(i_quat.z) * qvr_pkg::t_qprod'(i_quat.z);
        n_s1.xy  = qvr_pkg::t_qprod'(i_quat.x) * qvr_pkg::t_qprod'(i_quat.y);
        n_s1.xz  = qvr_pkg::t_qprod'(i_quat.x) * qvr_pkg::t_qprod'(i_quat.z);
        n_s1.yz  = qvr_pkg::t_qprod'(i_quat.y) * qvr_pkg::t_qprod'(i_quat.z);
        n_s1.wx  = qvr_pkg::t_qprod'(i_quat.w) * qvr_pkg::t_qprod'(i_quat.x);
        n_s1.wy  = qvr_pkg::t_qprod'(i_quat.w) * qvr_pkg::t_qprod'(i_quat.y);
        n_s1.wz  = qvr_pkg::t_qprod'(i_quat.w) * qvr_pkg::t_qprod'(i_quat.z);
        n_s1.dir = i_dir;
        n_s1.vec = i_vec;
    end

    // Entries of the body-to-earth matrix; the doubling is a left shift.
    always_comb begin
        w_m[0][0] = qvr_pkg::ENT_ONE
                  - ((qvr_pkg::t_entry'(r_s1.yy) + qvr_pkg::t_entry'(r_s1.zz)) <<< 1);
        w_m[0][1] = (qvr_pkg::t_entry'(r_s1.xy) - qvr_pkg::t_entry'(r_s1.wz)) <<< 1;
        w_m[0][2] = (qvr_pkg::t_entry'(r_s1.xz) + qvr_pkg::t_entry'(r_s1.wy)) <<< 1;
        w_m[1][0] = (qvr_pkg::t_entry'(r_s1.xy) + qvr_pkg::t_entry'(r_s1.wz)) <<< 1;
        w_m[1][1] = qvr_pkg::ENT_ONE
                  - ((qvr_pkg::t_entry'(r_s1.xx) + qvr_pkg::t_entry'(r_s1.zz)) <<< 1);
        w_m[1][2] = (qvr_pkg::t_entry'(r_s1.yz) - qvr_pkg::t_entry'(r_s1.wx)) <<< 1;
        w_m[2][0] = (qvr_pkg::t_entry'(r_s1.xz) - qvr_pkg::t_entry'(r_s1.wy)) <<< 1;
        w_m[2][1] = (qvr_pkg::t_entry'(r_s1.yz) + qvr_pkg::t_entry'(r_s1.wx)) <<< 1;
        w_m[2][2] = qvr_pkg::ENT_ONE
                  - ((qvr_pkg::t_entry'(r_s1.xx) + qvr_pkg::t_entry'(r_s1.yy)) <<< 1);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s2.m[i][j] = (r_s1.dir == qvr_pkg::DIR_EARTH_TO_BODY) ? w_m[j][i] : w_m[i][j];
            end
        end
        n_s2.vec = r_s1.vec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_valid) begin
            r_s1 <= n_s1;
        end
        if (w_s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

endmodule

FILE: hw/rtl/qvr_mac.sv
// ----------------------------------------------------------------------------
// qvr_mac: matrix-vector multiply and accumulate
// Two pipeline stages: nine entry-by-component products, then three row sums
// with the rounding half already added.
// ----------------------------------------------------------------------------
module qvr_mac (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qvr_pkg::t_mat   i_mat,
    output logic            o_valid,
    input  logic            i_ready,
    output qvr_pkg::t_acc3  o_acc
);

    logic                       r_s3_valid;
    qvr_pkg::t_term [2:0][2:0]  r_s3;
    qvr_pkg::t_term [2:0][2:0]  n_s3;
    logic                       r_s4_valid;
    qvr_pkg::t_acc3             r_s4;
    qvr_pkg::t_acc3             n_s4;
    logic                       w_s3_ready;
    logic                       w_s4_ready;

    assign w_s4_ready = !r_s4_valid || i_ready;
    assign w_s3_ready = !r_s3_valid || w_s4_ready;
    assign o_ready    = w_s3_ready;
    assign o_valid    = r_s4_valid;
    assign o_acc      = r_s4;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s3[i][j] = qvr_pkg::t_term'(i_mat.m[i][j]) * qvr_pkg::t_term'(i_mat.vec[j]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s4[i] = qvr_pkg::t_acc'(r_s3[i][0]) + qvr_pkg::t_acc'(r_s3[i][1])
                    + qvr_pkg::t_acc'(r_s3[i][2]) + qvr_pkg::ACC_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_s3_ready) begin
                r_s3_valid <= i_valid;
            end
            if (w_s4_ready) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_ready && i_valid) begin
            r_s3 <= n_s3;
        end
        if (w_s4_ready && r_s3_valid) begin
            r_s4 <= n_s4;
        end
    end

endmodule

FILE: hw/rtl/qvr_round.sv
// ----------------------------------------------------------------------------
// qvr_round: rounding, saturation and output register
// Drops the fraction bits of each row sum, clips to the vector range and
// flags any clipping. The register here is the block's output register.
// ----------------------------------------------------------------------------
module qvr_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qvr_pkg::t_acc3    i_acc,
    output logic              o_valid,
    input  logic              i_ready,
    output qvr_pkg::t_result  o_result
);

    logic              r_s5_valid;
    qvr_pkg::t_result  r_s5;
    qvr_pkg::t_result  n_s5;
    qvr_pkg::t_acc3    w_shift;
    logic [2:0]        w_clip;
    logic              w_s5_ready;

    assign w_s5_ready = !r_s5_valid || i_ready;
    assign o_ready    = w_s5_ready;
    assign o_valid    = r_s5_valid;
    assign o_result   = r_s5;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_shift[i] = i_acc[i] >>> qvr_pkg::FRAC_SHIFT;
            if (w_shift[i] > qvr_pkg::VEC_MAX) begin
                n_s5.vec[i] = qvr_pkg::t_vec'(qvr_pkg::VEC_MAX);
                w_clip[i]   = 1'b1;
            end else if (w_shift[i] < qvr_pkg::VEC_MIN) begin
                n_s5.vec[i] = qvr_pkg::t_vec'(qvr_pkg::VEC_MIN);
                w_clip[i]   = 1'b1;
            end else begin
                n_s5.vec[i] = qvr_pkg::t_vec'(w_shift[i]);
                w_clip[i]   = 1'b0;
            end
        end
        n_s5.sat = |w_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_s5_ready) begin
            r_s5_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s5_ready && i_valid) begin
            r_s5 <= n_s5;
        end
    end

endmodule

FILE: verif/rotation_checker.sv
// ----------------------------------------------------------------------------
// rotation_checker: predicts and compares the rotated vectors of the rotator
// Watches both stream channels of the block. Every accepted input transaction
// is turned into the exact rotated, rounded and saturated vector, and every
// accepted output transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module rotation_checker
    import qvr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    // tdata from bit 0 up: q_w, q_x, q_y, q_z, vec_x, vec_y, vec_z.
    input  logic [IN_DATA_W-1:0]   i_in_tdata,
    // tuser: opcode.
    input  logic [0:0]             i_in_tuser,
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    // tdata from bit 0 up: out_x, out_y, out_z.
    input  logic [OUT_DATA_W-1:0]  i_out_tdata,
    // tuser: saturated.
    input  logic [0:0]             i_out_tuser,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    typedef struct {
        t_vec out_x;
        t_vec out_y;
        t_vec out_z;
        logic saturated;
    } t_rotated;

    t_rotated rotated_q[$];
    t_rotated oldest;
    int       fail_total = 0;

    // Exact matrix-vector product at 2*QUAT_FRAC_BITS fraction bits. The
    // largest accumulated magnitude stays below 2^50, so 64 bits are plenty.
    function automatic t_rotated rotate_vector(input logic dir, input t_qcomp qw,
                                               input t_qcomp qx, input t_qcomp qy,
                                               input t_qcomp qz, input t_vec vx,
                                               input t_vec vy, input t_vec vz);
        longint   w, x, y, z, one, half, hi_lim, lo_lim, acc, rnd;
        longint   m [3][3];
        longint   v [3];
        t_vec     comp [3];
        t_rotated res;
        int       i, j;
        w      = longint'(qw);
        x      = longint'(qx);
        y      = longint'(qy);
        z      = longint'(qz);
        v[0]   = longint'(vx);
        v[1]   = longint'(vy);
        v[2]   = longint'(vz);
        one    = longint'(1) <<< FRAC_SHIFT;
        half   = longint'(1) <<< (FRAC_SHIFT - 1);
        hi_lim = (longint'(1) <<< (VECTOR_WIDTH - 1)) - 1;
        lo_lim = -(longint'(1) <<< (VECTOR_WIDTH - 1));
        m[0][0] = one - 2 * (y * y + z * z);
        m[0][1] = 2 * (x * y - w * z);
        m[0][2] = 2 * (x * z + w * y);
        m[1][0] = 2 * (x * y + w * z);
        m[1][1] = one - 2 * (x * x + z * z);
        m[1][2] = 2 * (y * z - w * x);
        m[2][0] = 2 * (x * z - w * y);
        m[2][1] = 2 * (y * z + w * x);
        m[2][2] = one - 2 * (x * x + y * y);
        res.saturated = 1'b0;
        for (i = 0; i < 3; i++) begin
            acc = 0;
            for (j = 0; j < 3; j++) begin
                // Earth to body uses the transpose of the matrix.
                acc += ((dir == DIR_EARTH_TO_BODY) ? m[j][i] : m[i][j]) * v[j];
            end
            // Floor of value plus one half: ties go toward plus infinity.
            rnd = (acc + half) >>> FRAC_SHIFT;
            if (rnd > hi_lim) begin
                rnd = hi_lim;
                res.saturated = 1'b1;
            end else if (rnd < lo_lim) begin
                rnd = lo_lim;
                res.saturated = 1'b1;
            end
            comp[i] = t_vec'(rnd);
        end
        res.out_x = comp[0];
        res.out_y = comp[1];
        res.out_z = comp[2];
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_tvalid && i_in_tready) begin
                rotated_q.push_back(rotate_vector(i_in_tuser[0],
                    t_qcomp'(i_in_tdata[0*QUAT_WIDTH +: QUAT_WIDTH]),
                    t_qcomp'(i_in_tdata[1*QUAT_WIDTH +: QUAT_WIDTH]),
                    t_qcomp'(i_in_tdata[2*QUAT_WIDTH +: QUAT_WIDTH]),
                    t_qcomp'(i_in_tdata[3*QUAT_WIDTH +: QUAT_WIDTH]),
                    t_vec'(i_in_tdata[4*QUAT_WIDTH + 0*VECTOR_WIDTH +: VECTOR_WIDTH]),
                    t_vec'(i_in_tdata[4*QUAT_WIDTH + 1*VECTOR_WIDTH +: VECTOR_WIDTH]),
                    t_vec'(i_in_tdata[4*QUAT_WIDTH + 2*VECTOR_WIDTH +: VECTOR_WIDTH])));
            end
            if (i_out_tvalid && i_out_tready) begin
                if (rotated_q.size() == 0) begin
                    $error("output transaction with no predicted rotation waiting");
                    fail_total++;
                end else begin
                    oldest = rotated_q.pop_front();
                    check_field("out_x", longint'(oldest.out_x),
                                longint'(t_vec'(i_out_tdata[0*VECTOR_WIDTH +: VECTOR_WIDTH])));
                    check_field("out_y", longint'(oldest.out_y),
                                longint'(t_vec'(i_out_tdata[1*VECTOR_WIDTH +: VECTOR_WIDTH])));
                    check_field("out_z", longint'(oldest.out_z),
                                longint'(t_vec'(i_out_tdata[2*VECTOR_WIDTH +: VECTOR_WIDTH])));
                    check_field("saturated", longint'(oldest.saturated),
                                longint'(i_out_tuser[0]));
                end
            end
        end
        o_mismatches  <= fail_total;
        o_outstanding <= rotated_q.size();
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the quaternion vector rotator
// Drives directed and random quaternion/vector transactions with random gaps
// on the input and random stalls on the output; a checker beside the block
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
    import qvr_pkg::*;

    localparam int RANDOM_ITEMS   = 600;
    localparam int WATCHDOG_LIMIT = 1000;
    // Five pipeline stages, plus some margin, after the last result.
    localparam int TAIL_CYCLES    = 20;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    int chk_mismatches;
    int chk_outstanding;
    int send_burst = 0;
    int recv_burst = 0;
    int idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    quaternion_vector_rotation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rotation_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .i_out_tuser   (m_axis_tuser),
        .o_mismatches  (chk_mismatches),
        .o_outstanding (chk_outstanding)
    );

    // Draws a random wait, or none at all inside a stretch of
    // back-to-back transactions.
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) burst = $urandom_range(10, 40);
        return $urandom_range(0, 15);
    endfunction

    // One input transaction: optional gap with tvalid low, then hold the item
    // until the block takes it. Inputs change only at the falling edge.
    task automatic send_rotation(input logic dir, input t_qcomp qw, input t_qcomp qx,
                                 input t_qcomp qy, input t_qcomp qz, input t_vec vx,
                                 input t_vec vy, input t_vec vz);
        int gap;
        gap = draw_wait(send_burst);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vz, vy, vx, qz, qy, qx, qw};
        s_axis_tuser  <= dir;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and hold off until every predicted result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (chk_outstanding != 0) @(posedge i_clk);
    endtask

    // A random attitude normalized to unit length in Q1.14.
    task automatic unit_quaternion(output t_qcomp qw, output t_qcomp qx,
                                   output t_qcomp qy, output t_qcomp qz);
        real rw, rx, ry, rz, norm;
        rw   = real'($urandom_range(0, 65535)) - 32768.0;
        rx   = real'($urandom_range(0, 65535)) - 32768.0;
        ry   = real'($urandom_range(0, 65535)) - 32768.0;
        rz   = real'($urandom_range(0, 65535)) - 32768.0;
        norm = $sqrt(rw * rw + rx * rx + ry * ry + rz * rz);
        if (norm < 1.0) begin
            rw   = 1.0;
            norm = 1.0;
        end
        qw = t_qcomp'($rtoi(rw / norm * 16384.0));
        qx = t_qcomp'($rtoi(rx / norm * 16384.0));
        qy = t_qcomp'($rtoi(ry / norm * 16384.0));
        qz = t_qcomp'($rtoi(rz / norm * 16384.0));
    endtask

    // Quaternion part from a coarse grid; half and whole steps make rounding
    // ties likely.
    function automatic t_qcomp coarse_part();
        return t_qcomp'(($urandom_range(0, 4) * 8192) - 16384);
    endfunction

    // Vector component within a few counts of either bound.
    function automatic t_vec extreme_component();
        if ($urandom_range(0, 1) == 1) return t_vec'(32767 - $urandom_range(0, 15));
        return t_vec'(-32768 + int'($urandom_range(0, 15)));
    endfunction

    // Output side: random stalls with tready low, then ready until one
    // result transaction goes through.
    initial begin : result_sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = draw_wait(recv_burst);
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Ends the run when neither channel has moved a transaction for too long.
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("quaternion_vector_rotation verification failed");
        $finish;
    end

    initial begin : stimulus
        t_qcomp qw, qx, qy, qz;
        t_vec   vx, vy, vz;
        logic   dir;
        int     sel;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Identity attitude in both directions, with the vector extremes.
        send_rotation(DIR_BODY_TO_EARTH, 16384, 0, 0, 0, 1, -1, 0);
        send_rotation(DIR_EARTH_TO_BODY, 16384, 0, 0, 0, 32767, -32768, 0);
        send_rotation(DIR_BODY_TO_EARTH, 16384, 0, 0, 0, -32768, 32767, -32768);
        // Ninety degrees about z, where the two directions turn opposite ways, then about x.
        send_rotation(DIR_BODY_TO_EARTH, 11585, 0, 0, 11585, 1000, 0, 0);
        send_rotation(DIR_EARTH_TO_BODY, 11585, 0, 0, 11585, 1000, 0, 0);
        send_rotation(DIR_EARTH_TO_BODY, 11585, 11585, 0, 0, 0, 2000, -3000);
        // The zero quaternion still gives the identity matrix.
        send_rotation(DIR_BODY_TO_EARTH, 0, 0, 0, 0, 12345, -23456, 32767);
        // Most negative operands everywhere, then most positive ones.
        send_rotation(DIR_BODY_TO_EARTH, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768);
        send_rotation(DIR_EARTH_TO_BODY, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768);
        send_rotation(DIR_BODY_TO_EARTH, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_rotation(DIR_EARTH_TO_BODY, 32767, -32768, 32767, -32768, 32767, 32767, 1);
        // A non-unit quaternion scales the vector and may clip it.
        send_rotation(DIR_BODY_TO_EARTH, 0, 32767, 0, 0, 10000, 10000, 10000);
        send_rotation(DIR_EARTH_TO_BODY, 32767, 0, 0, 32767, 100, -100, 5);
        // Half turn about x: negating -32768 overflows and saturates.
        send_rotation(DIR_BODY_TO_EARTH, 0, 16384, 0, 0, -32768, -32768, 100);
        send_rotation(DIR_EARTH_TO_BODY, 0, 16384, 0, 0, 7, -32768, -32768);
        // q_y of one half halves x and z exactly (q_x: y and z): results land on ties.
        send_rotation(DIR_BODY_TO_EARTH, 0, 0, 8192, 0, 3, 7, -3);
        send_rotation(DIR_EARTH_TO_BODY, 0, 0, 8192, 0, -1, 0, 1);
        send_rotation(DIR_BODY_TO_EARTH, 0, 0, 8192, 0, 32767, -5, -32767);
        send_rotation(DIR_EARTH_TO_BODY, 0, 8192, 0, 0, 9, -9, 11);

        // Let the pipeline empty completely before the random part.
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain_results();
            dir = logic'($urandom_range(0, 1));
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                // Realistic attitude, any vector.
                unit_quaternion(qw, qx, qy, qz);
                vx = t_vec'($urandom);
                vy = t_vec'($urandom);
                vz = t_vec'($urandom);
            end else if (sel < 70) begin
                // Every field drawn over its full range.
                qw = t_qcomp'($urandom);
                qx = t_qcomp'($urandom);
                qy = t_qcomp'($urandom);
                qz = t_qcomp'($urandom);
                vx = t_vec'($urandom);
                vy = t_vec'($urandom);
                vz = t_vec'($urandom);
            end else if (sel < 85) begin
                qw = coarse_part();
                qx = coarse_part();
                qy = coarse_part();
                qz = coarse_part();
                vx = t_vec'($urandom_range(0, 2000) - 1000);
                vy = t_vec'($urandom_range(0, 2000) - 1000);
                vz = t_vec'($urandom_range(0, 2000) - 1000);
            end else begin
                // Unit attitude with a vector at the bounds: rounding may clip.
                unit_quaternion(qw, qx, qy, qz);
                vx = extreme_component();
                vy = extreme_component();
                vz = extreme_component();
            end
            send_rotation(dir, qw, qx, qy, qz, vx, vy, vz);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (chk_mismatches == 0 && chk_outstanding == 0)
            $display("quaternion_vector_rotation verification clean");
        else
            $display("quaternion_vector_rotation verification failed");
        $finish;
    end

endmodule
